// ===== rtl/core/sgab_pkg.sv =====
// Package for the scaled glyph additive blitter: shared types and constants.
// Holds item kind codes, register indexes, reset values and the command struct.
// No dependencies.
package sgab_pkg;

	// Field widths.
	localparam int KIND_W     = 2;
	localparam int ADDR_W     = 14;
	localparam int PIX_W      = 8;
	localparam int ROW_W      = 7;
	localparam int WOB_W      = 4;
	localparam int COL_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_START = 2'd2;
	localparam logic [KIND_W-1:0] KIND_GLYPH = 2'd3;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTEN_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ROW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WOBBLE_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LIMIT  = 3'd4;

	// Register reset values.
	localparam logic [PIX_W-1:0] RST_BRIGHTEN_STEP = 8'd8;
	localparam logic [PIX_W-1:0] RST_CEILING       = 8'd50;
	localparam logic [ROW_W-1:0] RST_BASE_ROW      = 7'd40;
	localparam logic [WOB_W-1:0] RST_WOBBLE_STEP   = 4'd5;
	localparam logic [COL_W-1:0] RST_COLUMN_LIMIT  = 8'd160;

	// Drawing geometry: 4 sub-columns, 8 glyph cells of 8 rows each.
	localparam int SUB_W     = 2;
	localparam int ROW_IDX_W = 6;
	localparam int DRAW_ROWS = 64;
	localparam int COL_MAX   = 2**COL_W - 1;
	// Largest row reached: base row, row offset and the last drawn row.
	localparam int ROW_SPAN_MAX = (2**ROW_W - 1) + 3 + (DRAW_ROWS - 1);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                 load;
		logic                 read;
		logic                 start;
		logic                 glyph;
		logic                 setup;
		logic                 issue;
		logic [ROW_IDX_W-1:0] row;
		logic                 col_step;
		logic                 load_out;
	} sgab_cmd_t;

endpackage

// ===== rtl/core/sgab_ctrl.sv =====
// Controller of the scaled glyph additive blitter: input and output handshake,
// state machine and draw counters. Depends on sgab_pkg.
module sgab_ctrl
	import sgab_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] kind,
	input  logic              out_stall,
	output logic              in_stall,
	output logic              out_valid,
	output sgab_cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RDWAIT = 3'd1;
	localparam logic [2:0] ST_SETUP  = 3'd2;
	localparam logic [2:0] ST_DRAW   = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;

	localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(DRAW_ROWS - 1);
	localparam logic [SUB_W-1:0]     LAST_SUB = '1;

	logic [2:0]           state_q;
	logic [ROW_IDX_W-1:0] row_q;
	logic [SUB_W-1:0]     sub_q;
	logic                 out_valid_q;
	logic                 accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && (state_q == ST_IDLE);

	// Command decode from the state and the accepted transaction.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_LOAD:  cmd.load  = 1'b1;
						KIND_READ:  cmd.read  = 1'b1;
						KIND_START: cmd.start = 1'b1;
						default:    cmd.glyph = 1'b1;
					endcase
				end
			end
			ST_RDWAIT: cmd.load_out = !out_valid_q || !out_stall;
			ST_SETUP:  cmd.setup = 1'b1;
			ST_DRAW: begin
				cmd.issue    = 1'b1;
				cmd.row      = row_q;
				cmd.col_step = (row_q == LAST_ROW);
			end
			default: ;
		endcase
	end

	// State machine and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			sub_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.read)
						state_q <= ST_RDWAIT;
					else if (cmd.glyph)
						state_q <= ST_SETUP;
				end
				ST_RDWAIT: begin
					if (cmd.load_out)
						state_q <= ST_IDLE;
				end
				ST_SETUP: begin
					row_q   <= '0;
					sub_q   <= '0;
					state_q <= ST_DRAW;
				end
				ST_DRAW: begin
					row_q <= row_q + 1'b1;
					if (row_q == LAST_ROW) begin
						sub_q <= sub_q + 1'b1;
						if (sub_q == LAST_SUB)
							state_q <= ST_DRAIN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output valid: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

endmodule

// ===== rtl/core/sgab_dp.sv =====
// Datapath of the scaled glyph additive blitter: registers, frame store,
// draw address generation and the brighten pipeline. Depends on sgab_pkg.
module sgab_dp
	import sgab_pkg::*;
#(
	parameter int LINE_WIDTH = 160,
	parameter int STORE_SIZE = 16384
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  sgab_cmd_t             cmd,
	input  logic [ADDR_W-1:0]     address,
	input  logic [PIX_W-1:0]      value,
	input  logic [PIX_W-1:0]      glyph_bits,
	output logic [PIX_W-1:0]      pixel_value,
	output logic                  draw_wr
);

	localparam int DRAW_MAX = COL_MAX + ROW_SPAN_MAX * LINE_WIDTH;
	localparam int DRAW_W   = $clog2(DRAW_MAX + 1);
	localparam int SIZE_W   = $clog2(STORE_SIZE + 1);
	localparam int IDX_W    = $clog2(STORE_SIZE);
	localparam int W1       = (DRAW_W > ADDR_W) ? DRAW_W : ADDR_W;
	localparam int CMP_W    = (W1 > SIZE_W) ? W1 : SIZE_W;

	localparam logic [CMP_W-1:0]  STORE_END = CMP_W'(STORE_SIZE);
	localparam logic [DRAW_W-1:0] LINE_STEP = DRAW_W'(LINE_WIDTH);

	// Configuration registers.
	logic [PIX_W-1:0] brighten_step_q;
	logic [PIX_W-1:0] ceiling_q;
	logic [ROW_W-1:0] base_row_q;
	logic [WOB_W-1:0] wobble_step_q;
	logic [COL_W-1:0] column_limit_q;

	// Text state.
	logic [WOB_W-1:0] wobble_q;
	logic [COL_W-1:0] col_pos_q;
	logic [1:0]       row_sel_q;

	// Draw state.
	logic [PIX_W-1:0]  bits_q;
	logic [DRAW_W-1:0] row_base_q;
	logic [DRAW_W-1:0] addr_q;
	logic              valid_s1;
	logic [IDX_W-1:0]  addr_s1;

	// Frame store.
	logic [PIX_W-1:0] mem [STORE_SIZE];
	logic [PIX_W-1:0] rdata_q;
	logic             rd_oor_q;
	logic [PIX_W-1:0] pixel_q;

	logic [WOB_W-1:0] wobble_next;
	logic [COL_W:0]   col_inc;
	logic [COL_W-1:0] next_col;
	logic [COL_W-1:0] row_sum;
	logic [CMP_W-1:0] in_ext;
	logic [CMP_W-1:0] draw_ext;
	logic             in_ok;
	logic             draw_ok;
	logic             draw_rd;
	logic             mem_we;
	logic [IDX_W-1:0] mem_widx;
	logic [PIX_W-1:0] mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_ridx;
	logic [PIX_W:0]   sum;
	logic [PIX_W-1:0] bright;

	// Next wobble count, next column position and row sum.
	assign wobble_next = wobble_q + wobble_step_q;
	assign col_inc     = {1'b0, col_pos_q} + (COL_W + 1)'(1);
	assign next_col    = (col_inc > {1'b0, column_limit_q}) ? '0 : col_inc[COL_W-1:0];
	assign row_sum     = {1'b0, base_row_q} + {{(COL_W - 2){1'b0}}, row_sel_q};

	// Range checks for host and draw addresses.
	assign in_ext   = CMP_W'(address);
	assign draw_ext = CMP_W'(addr_q);
	assign in_ok    = (in_ext < STORE_END);
	assign draw_ok  = (draw_ext < STORE_END);
	assign draw_rd  = cmd.issue && bits_q[cmd.row[ROW_IDX_W-1:3]] && draw_ok;

	// Saturating brighten with ceiling clamp.
	assign sum    = {1'b0, rdata_q} + {1'b0, brighten_step_q};
	assign bright = (sum > {1'b0, ceiling_q}) ? ceiling_q : sum[PIX_W-1:0];

	// Memory port selection: the draw pipeline or the host transaction.
	assign mem_we    = valid_s1 || (cmd.load && in_ok);
	assign mem_widx  = valid_s1 ? addr_s1 : in_ext[IDX_W-1:0];
	assign mem_wdata = valid_s1 ? bright : value;
	assign mem_re    = draw_rd || (cmd.read && in_ok);
	assign mem_ridx  = draw_rd ? draw_ext[IDX_W-1:0] : in_ext[IDX_W-1:0];

	assign draw_wr     = valid_s1;
	assign pixel_value = pixel_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brighten_step_q <= RST_BRIGHTEN_STEP;
			ceiling_q       <= RST_CEILING;
			base_row_q      <= RST_BASE_ROW;
			wobble_step_q   <= RST_WOBBLE_STEP;
			column_limit_q  <= RST_COLUMN_LIMIT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BRIGHTEN_STEP: brighten_step_q <= cfg_data;
				REG_CEILING:       ceiling_q       <= cfg_data;
				REG_BASE_ROW:      base_row_q      <= cfg_data[ROW_W-1:0];
				REG_WOBBLE_STEP:   wobble_step_q   <= cfg_data[WOB_W-1:0];
				REG_COLUMN_LIMIT:  column_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Wobble counter, column position and row offset select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wobble_q  <= '0;
			col_pos_q <= '0;
			row_sel_q <= '0;
		end else if (cmd.start) begin
			wobble_q  <= wobble_next;
			col_pos_q <= {{(COL_W - 2){1'b0}}, wobble_next[1:0]};
			row_sel_q <= wobble_next[3:2];
		end else if (cmd.col_step) begin
			col_pos_q <= next_col;
		end
	end

	// Draw address generation: one row per cycle, new column per sub-column.
	always_ff @(posedge clk) begin
		if (cmd.glyph) begin
			bits_q     <= glyph_bits;
			row_base_q <= DRAW_W'(int'(row_sum) * LINE_WIDTH);
		end
		if (cmd.setup)
			addr_q <= row_base_q + DRAW_W'(col_pos_q);
		else if (cmd.col_step)
			addr_q <= row_base_q + DRAW_W'(next_col);
		else if (cmd.issue)
			addr_q <= addr_q + LINE_STEP;
	end

	// Pipeline stage between the read and the write of a drawn pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= draw_rd;
	end

	always_ff @(posedge clk) begin
		addr_s1 <= draw_ext[IDX_W-1:0];
	end

	// Frame store write port.
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_widx] <= mem_wdata;
	end

	// Frame store read port with registered data.
	always_ff @(posedge clk) begin
		if (mem_re)
			rdata_q <= mem[mem_ridx];
	end

	// Read result: out-of-range reads return zero.
	always_ff @(posedge clk) begin
		if (cmd.read)
			rd_oor_q <= !in_ok;
		if (cmd.load_out)
			pixel_q <= rd_oor_q ? '0 : rdata_q;
	end

endmodule

// ===== rtl/core/scaled_glyph_additive_blitter.sv =====
// Top level of the scaled glyph additive blitter: controller plus datapath.
// Depends on sgab_pkg, sgab_ctrl and sgab_dp.
//
// Usage: items arrive on the input channel (in_valid/in_stall) with a kind,
// an address, a value and one glyph column. Loads write a pixel, reads return
// one pixel on the output channel (out_valid/out_stall), start-text items step
// the wobble counter, and glyph columns are drawn 4 pixels wide and 8 rows per
// set bit with saturating brightening.
// A load or a start-text item is taken and the block stays idle. A read reads
// the store, waits in the read-wait state until the output can take a result,
// then loads it and returns to idle. A glyph column runs through a setup state,
// one pixel per cycle over 4 sub-columns of 64 rows, and a drain state that
// finishes the last write; the frame store reads and writes one pixel per cycle.
// The config port writes a register at any clock edge with cfg_write high;
// write it only while the block is idle.
// Reset clears the wobble counter, column position and handshake state and
// restores register defaults; the frame store holds nothing until loaded.
// While the receiver stalls, a waiting result holds; loads, start-text and
// glyph items are still accepted, and a further read waits for the output.
module scaled_glyph_additive_blitter
	import sgab_pkg::*;
#(
	parameter int LINE_WIDTH = 160,
	parameter int STORE_SIZE = 16384
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [KIND_W-1:0]     kind,
	input  logic [ADDR_W-1:0]     address,
	input  logic [PIX_W-1:0]      value,
	input  logic [PIX_W-1:0]      glyph_bits,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      pixel_value
);

	sgab_cmd_t cmd;
	logic      draw_wr;

	// Controller.
	sgab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Datapath.
	sgab_dp #(
		.LINE_WIDTH (LINE_WIDTH),
		.STORE_SIZE (STORE_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.address     (address),
		.value       (value),
		.glyph_bits  (glyph_bits),
		.pixel_value (pixel_value),
		.draw_wr     (draw_wr)
	);

`ifndef SYNTHESIS
	// A drawn pixel is written back only while no transaction can enter.
	assert property (@(posedge clk) disable iff (!arst_n) draw_wr |-> in_stall)
		else $error("draw write-back while input open");

	// A read result never overwrites one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("read result overwrites waiting result");

	// A result appears only after the controller loaded it.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.load_out))
		else $error("result without a read");
`endif

endmodule

// ===== test/tb_scaled_glyph_additive_blitter.sv =====
// Self-checking testbench for scaled_glyph_additive_blitter: directed and random traffic.
// A shadow of the frame store and text state predicts every pixel read.
// Depends on sgab_pkg and the blitter RTL; needs no files or arguments.
module tb_scaled_glyph_additive_blitter;
	timeunit 1ns;
	timeprecision 1ps;
	import sgab_pkg::*;

	localparam int LINE_W       = 160;
	localparam int STORE_DEPTH  = 16384;
	localparam int GLYPH_CYCLES = 259;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 70;
	localparam int MAX_REPORTS  = 50;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_write   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [KIND_W-1:0]     kind        = KIND_LOAD;
	logic [ADDR_W-1:0]     address     = '0;
	logic [PIX_W-1:0]      value       = '0;
	logic [PIX_W-1:0]      glyph_bits  = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [PIX_W-1:0]      pixel_value;

	// Shadow of the frame store and of the text drawing state.
	logic [PIX_W-1:0] pixel_mem [STORE_DEPTH];
	bit               pixel_loaded [STORE_DEPTH];
	int unsigned      loaded_addrs[$];
	int unsigned      drawn_addrs[$];
	logic [PIX_W-1:0] expected_pixels[$];
	logic [WOB_W-1:0] wobble       = '0;
	logic [COL_W-1:0] column       = '0;
	logic [1:0]       row_select   = '0;
	logic [PIX_W-1:0] step_reg     = RST_BRIGHTEN_STEP;
	logic [PIX_W-1:0] ceiling_reg  = RST_CEILING;
	logic [ROW_W-1:0] base_reg     = RST_BASE_ROW;
	logic [WOB_W-1:0] wob_step_reg = RST_WOBBLE_STEP;
	logic [COL_W-1:0] limit_reg    = RST_COLUMN_LIMIT;

	int unsigned mismatches = 0;
	int unsigned n_items    = 0;
	int unsigned n_checked  = 0;
	int unsigned n_glyphs   = 0;
	int unsigned n_frames   = 0;
	int unsigned n_settings = 0;
	bit          quiet_source = 1'b0;
	bit          quiet_sink   = 1'b0;
	int unsigned sink_left    = 0;

	scaled_glyph_additive_blitter #(
		.LINE_WIDTH(LINE_W),
		.STORE_SIZE(STORE_DEPTH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.address    (address),
		.value      (value),
		.glyph_bits (glyph_bits),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_value(pixel_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Ends the run if the block hangs.
	initial begin
		#100ms;
		$display("TEST FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
			input logic [PIX_W-1:0] want);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t ns: %s: pixel_value %0d, expected %0d", $time, what, got, want);
		end
	endtask

	// Column position after one sub-column, wrapping past the limit.
	function automatic logic [COL_W-1:0] next_column(input logic [COL_W-1:0] col);
		logic [COL_W:0] nxt;
		nxt = {1'b0, col} + 1'b1;
		if (nxt > {1'b0, limit_reg}) begin
			return '0;
		end
		return nxt[COL_W-1:0];
	endfunction

	// Store address of row r of glyph cell b in the sub-column at col.
	function automatic int unsigned glyph_pixel(input logic [COL_W-1:0] col, input int b,
			input int r);
		return int'(col) + (int'(row_select) + int'(base_reg) + b * 8 + r) * LINE_W;
	endfunction

	// Applies one accepted transaction to the shadow state.
	function automatic void predict_item(input logic [KIND_W-1:0] k,
			input logic [ADDR_W-1:0] a, input logic [PIX_W-1:0] v,
			input logic [PIX_W-1:0] g);
		logic [COL_W-1:0] col;
		logic [PIX_W:0]   sum;
		int unsigned      pa;
		case (k)
			KIND_LOAD: begin
				pixel_mem[a] = v;
				if (!pixel_loaded[a]) begin
					pixel_loaded[a] = 1'b1;
					loaded_addrs.push_back(32'(a));
				end
			end
			KIND_READ: begin
				expected_pixels.push_back(pixel_mem[a]);
			end
			KIND_START: begin
				wobble     = wobble + wob_step_reg;
				column     = {{(COL_W-2){1'b0}}, wobble[1:0]};
				row_select = wobble[3:2];
				n_frames++;
			end
			default: begin
				drawn_addrs.delete();
				for (int s = 0; s < 4; s++) begin
					col    = column;
					column = next_column(column);
					for (int b = 0; b < 8; b++) begin
						if (g[b]) begin
							for (int r = 0; r < 8; r++) begin
								pa = glyph_pixel(col, b, r);
								// Pixels beyond the store are skipped.
								if (pa < STORE_DEPTH) begin
									sum = {1'b0, pixel_mem[pa[ADDR_W-1:0]]} + {1'b0, step_reg};
									if (sum > {1'b0, ceiling_reg}) begin
										sum = {1'b0, ceiling_reg};
									end
									pixel_mem[pa[ADDR_W-1:0]] = sum[PIX_W-1:0];
									drawn_addrs.push_back(pa);
								end
							end
						end
					end
				end
			end
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet_source) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20) return '0;
		if (r < 40) return '1;
		if (r < 60) return ceiling_reg;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	// Mostly sparse columns, so that few fresh pixels need loading first.
	function automatic logic [PIX_W-1:0] pick_glyph();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25) return '0;
		if (r < 30) return '1;
		if (r < 75) return PIX_W'(1 << $urandom_range(0, 7));
		return PIX_W'($urandom_range(0, 255) & $urandom_range(0, 255));
	endfunction

	function automatic logic [PIX_W-1:0] pick_extreme_byte();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2) return '0;
		if (r < 4) return '1;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	// Reads only touch loaded pixels, often the ones just drawn.
	function automatic logic [ADDR_W-1:0] pick_readable();
		if (drawn_addrs.size() > 0 && $urandom_range(0, 1)) begin
			return ADDR_W'(drawn_addrs[$urandom_range(0, drawn_addrs.size() - 1)]);
		end
		return ADDR_W'(loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)]);
	endfunction

	// Sends one transaction after an optional gap and returns once it is accepted.
	task automatic send_item(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
			input logic [PIX_W-1:0] v, input logic [PIX_W-1:0] g);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid   <= 1'b0;
			kind       <= KIND_W'($urandom_range(0, 3));
			address    <= ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
			value      <= PIX_W'($urandom_range(0, 255));
			glyph_bits <= PIX_W'($urandom_range(0, 255));
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		address    <= a;
		value      <= v;
		glyph_bits <= g;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_item(k, a, v, g);
		n_items++;
	endtask

	// Loads every pixel the next glyph column will touch that was never written.
	task automatic prime_glyph(input logic [PIX_W-1:0] g);
		logic [COL_W-1:0] col;
		int unsigned      pa;
		col = column;
		for (int s = 0; s < 4; s++) begin
			for (int b = 0; b < 8; b++) begin
				if (g[b]) begin
					for (int r = 0; r < 8; r++) begin
						pa = glyph_pixel(col, b, r);
						if (pa < STORE_DEPTH && !pixel_loaded[pa[ADDR_W-1:0]]) begin
							send_item(KIND_LOAD, pa[ADDR_W-1:0], pick_pixel(),
								PIX_W'($urandom_range(0, 255)));
						end
					end
				end
			end
			col = next_column(col);
		end
	endtask

	task automatic send_glyph(input logic [PIX_W-1:0] g);
		prime_glyph(g);
		send_item(KIND_GLYPH, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)),
			PIX_W'($urandom_range(0, 255)), g);
		n_glyphs++;
	endtask

	task automatic send_start();
		send_item(KIND_START, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)),
			PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
	endtask

	task automatic read_pixels(input int unsigned n);
		repeat (n) begin
			send_item(KIND_READ, pick_readable(), PIX_W'($urandom_range(0, 255)),
				PIX_W'($urandom_range(0, 255)));
		end
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
	endtask

	// Idle point: all reads returned and any glyph column finished drawing.
	task automatic wait_idle();
		hold_until_drained();
		repeat (GLYPH_CYCLES + 16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		case (idx)
			REG_BRIGHTEN_STEP: step_reg     = d;
			REG_CEILING:       ceiling_reg  = d;
			REG_BASE_ROW:      base_reg     = d[ROW_W-1:0];
			REG_WOBBLE_STEP:   wob_step_reg = d[WOB_W-1:0];
			REG_COLUMN_LIMIT:  limit_reg    = d;
			default: ;
		endcase
	endtask

	// Writes every register, plus an unmapped index that must be ignored.
	task automatic configure(input logic [7:0] stp, input logic [7:0] ceil,
			input logic [7:0] base, input logic [7:0] wob, input logic [7:0] lim);
		write_reg(REG_BRIGHTEN_STEP, stp);
		write_reg(REG_CEILING, ceil);
		write_reg(REG_BASE_ROW, base);
		write_reg(REG_WOBBLE_STEP, wob);
		write_reg(REG_COLUMN_LIMIT, lim);
		write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom_range(0, 255)));
		cfg_write <= 1'b0;
		n_settings++;
	endtask

	// Plain loads and reads at the extremes of address and value.
	task automatic test_pixel_access();
		send_item(KIND_LOAD, '0, '0, '1);
		send_item(KIND_LOAD, '1, '1, '0);
		send_item(KIND_READ, '0, '1, '1);
		send_item(KIND_READ, '1, '0, '0);
	endtask

	// One text frame with the reset register values.
	task automatic test_default_text();
		send_start();
		send_glyph(8'h3C);
		send_glyph(8'h00);
		send_glyph(8'h80);
		read_pixels(3);
	endtask

	// Register extremes: text entirely below the store, a zero ceiling,
	// and a full-width sum that saturates at the top.
	task automatic test_register_extremes();
		wait_idle();
		configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_start();
		send_glyph(8'hFF);
		read_pixels(1);
		wait_idle();
		configure(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_start();
		send_glyph(8'h81);
		read_pixels(2);
		wait_idle();
		configure(8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00);
		send_glyph(8'h55);
		read_pixels(2);
	endtask

	// Column position wrapping at a small limit, with rows straddling the store end.
	task automatic test_column_wrap();
		wait_idle();
		configure(8'd20, 8'd200, 8'd100, 8'd3, 8'd3);
		send_start();
		send_glyph(8'hFF);
		send_glyph(8'h81);
		read_pixels(2);
	endtask

	// Phases of random settings; mostly text frames with reads, the rest noise.
	// Each phase runs until it has sent its share of transactions, loads included.
	task automatic test_random_traffic();
		int unsigned       phase_start;
		int unsigned       ncol;
		int unsigned       r;
		bit                long_frame;
		bit                long_frame_due;
		logic [7:0]        base;
		logic [7:0]        lim;
		logic [ADDR_W-1:0] a;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			base = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 90) :
				$urandom_range(0, 255));
			r = $urandom_range(0, 9);
			if (ph == 0 || r < 3) lim = 8'd255;
			else if (r < 5) lim = 8'd160;
			else if (r < 7) lim = 8'($urandom_range(0, 7));
			else lim = 8'($urandom_range(0, 255));
			configure(pick_extreme_byte(), pick_extreme_byte(), base, pick_extreme_byte(), lim);
			quiet_source   = (ph == 2);
			quiet_sink     = (ph == 2) || (ph == 4);
			// A long frame runs the column past the end of a line.
			long_frame_due = (ph == 0);
			phase_start    = n_items;
			while (n_items - phase_start < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					long_frame = long_frame_due || ($urandom_range(0, 19) == 0);
					if (long_frame) begin
						ncol = $urandom_range(41, 45);
					end else begin
						ncol = $urandom_range(1, 6);
					end
					long_frame_due = 1'b0;
					send_start();
					for (int unsigned c = 0; c < ncol; c++) begin
						// A long frame is mostly blank padding; only its tail is drawn.
						if (long_frame && c + 4 < ncol) begin
							send_glyph('0);
						end else begin
							send_glyph(pick_glyph());
						end
						if ($urandom_range(0, 1)) begin
							read_pixels($urandom_range(1, 2));
						end
					end
				end else if (r < 62) begin
					if (drawn_addrs.size() > 0 && $urandom_range(0, 9) < 3) begin
						a = ADDR_W'(drawn_addrs[$urandom_range(0, drawn_addrs.size() - 1)]);
					end else begin
						a = ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
					end
					send_item(KIND_LOAD, a, pick_pixel(), PIX_W'($urandom_range(0, 255)));
				end else if (r < 87) begin
					read_pixels(1);
				end else if (r < 92) begin
					send_start();
				end else if (r < 97) begin
					send_glyph(pick_glyph());
				end else begin
					hold_until_drained();
				end
			end
		end
		quiet_source = 1'b0;
		quiet_sink   = 1'b0;
	endtask

	// Output side stall: mostly short bursts, sometimes long ones.
	always @(posedge clk) begin
		if (quiet_sink) begin
			out_stall <= 1'b0;
			sink_left = 0;
		end else if (sink_left > 0) begin
			sink_left--;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			sink_left = $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b1;
			sink_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) :
				$urandom_range(15, 50);
		end
	end

	// Each accepted result transaction is matched against the oldest expected pixel.
	always @(posedge clk) begin : check_results
		logic [PIX_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("result with no read pending", pixel_value, '0);
			end else begin
				want = expected_pixels.pop_front();
				n_checked++;
				if (pixel_value !== want) begin
					report_mismatch("read data", pixel_value, want);
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pixel_access();
		test_default_text();
		test_register_extremes();
		test_column_wrap();
		test_random_traffic();
		wait_idle();
		$display("Run covered %0d transactions, %0d checked reads, %0d glyph columns,",
			n_items, n_checked, n_glyphs);
		$display("%0d text frames and %0d register settings.", n_frames, n_settings);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/sgab_pkg.sv
rtl/core/sgab_ctrl.sv
rtl/core/sgab_dp.sv
rtl/core/scaled_glyph_additive_blitter.sv
test/tb_scaled_glyph_additive_blitter.sv
